/* src/apic_tmr_pkg.sv */
// Package: word types, register offsets, op codes and divide decoding for the APIC timer.
package apic_tmr_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  reg_offset;
      logic [31:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_fire;
      logic [7:0]  irq_vector;
   } rsp_word_type;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [9:0] OFS_LVT_TIMER  = 10'h320;
   localparam logic [9:0] OFS_INIT_COUNT = 10'h380;
   localparam logic [9:0] OFS_CUR_COUNT  = 10'h390;
   localparam logic [9:0] OFS_DIVIDE     = 10'h3E0;

   localparam logic [1:0] MODE_PERIODIC = 2'd1;
   localparam logic [2:0] DIV_BY_ONE    = 3'd7;

   // divisor for code bits 3,1,0; bit 2 is reserved
   function automatic logic [7:0] divisor_of(input logic [3:0] code);
      logic [2:0] v;
      v = {code[3], code[1:0]};
      if (v == DIV_BY_ONE) begin
         divisor_of = 8'd1;
      end else begin
         divisor_of = 8'd2 << v;
      end
   endfunction

endpackage

/* src/apic_tmr_core.sv */
// Timer core: register state, prescaler, counter and one-word result logic.
module apic_tmr_core
   import apic_tmr_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type word,
   output rsp_word_type result
);

   logic [7:0]            lvt_vector_ff, lvt_vector_in;
   logic                  lvt_masked_ff, lvt_masked_in;
   logic [1:0]            lvt_mode_ff, lvt_mode_in;
   logic [COUNT_BITS-1:0] initial_count_ff, initial_count_in;
   logic [COUNT_BITS-1:0] current_count_ff, current_count_in;
   logic [3:0]            divide_code_ff, divide_code_in;
   logic [6:0]            prescale_count_ff, prescale_count_in;

   logic [7:0]            prescale_next;
   logic [COUNT_BITS-1:0] count_dec;

   assign prescale_next = {1'b0, prescale_count_ff} + 8'd1;
   assign count_dec     = current_count_ff - COUNT_BITS'(1);

   always_comb begin
      lvt_vector_in     = lvt_vector_ff;
      lvt_masked_in     = lvt_masked_ff;
      lvt_mode_in       = lvt_mode_ff;
      initial_count_in  = initial_count_ff;
      current_count_in  = current_count_ff;
      divide_code_in    = divide_code_ff;
      prescale_count_in = prescale_count_ff;
      result            = '0;
      case (word.op)
         OP_TICK: begin
            if (current_count_ff != '0) begin
               if (prescale_next < divisor_of(divide_code_ff)) begin
                  prescale_count_in = prescale_next[6:0];
               end else begin
                  prescale_count_in = '0;
                  current_count_in  = count_dec;
                  if (count_dec == '0) begin
                     if (lvt_mode_ff == MODE_PERIODIC) begin
                        current_count_in = initial_count_ff;
                     end
                     if (!lvt_masked_ff) begin
                        result.irq_fire   = 1'b1;
                        result.irq_vector = lvt_vector_ff;
                     end
                  end
               end
            end
         end
         OP_READ: begin
            case (word.reg_offset)
               OFS_LVT_TIMER: begin
                  result.read_data = {13'd0, lvt_mode_ff, lvt_masked_ff, 8'd0, lvt_vector_ff};
               end
               OFS_INIT_COUNT: result.read_data = 32'(initial_count_ff);
               OFS_CUR_COUNT:  result.read_data = 32'(current_count_ff);
               OFS_DIVIDE:     result.read_data = {28'd0, divide_code_ff};
               default:        result.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (word.reg_offset)
               OFS_LVT_TIMER: begin
                  lvt_vector_in = word.write_data[7:0];
                  lvt_masked_in = word.write_data[16];
                  lvt_mode_in   = word.write_data[18:17];
               end
               OFS_INIT_COUNT: begin
                  initial_count_in  = COUNT_BITS'(word.write_data);
                  current_count_in  = COUNT_BITS'(word.write_data);
                  prescale_count_in = '0;
               end
               OFS_DIVIDE: divide_code_in = word.write_data[3:0];
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvt_vector_ff     <= '0;
         lvt_masked_ff     <= 1'b1;
         lvt_mode_ff       <= '0;
         initial_count_ff  <= '0;
         current_count_ff  <= '0;
         divide_code_ff    <= '0;
         prescale_count_ff <= '0;
      end else if (accept) begin
         lvt_vector_ff     <= lvt_vector_in;
         lvt_masked_ff     <= lvt_masked_in;
         lvt_mode_ff       <= lvt_mode_in;
         initial_count_ff  <= initial_count_in;
         current_count_ff  <= current_count_in;
         divide_code_ff    <= divide_code_in;
         prescale_count_ff <= prescale_count_in;
      end
   end

endmodule

/* src/apic_countdown_timer_top.sv */
// Top level of the APIC countdown timer: request intake, core and two-deep result buffer.
//
//   channel  direction  handshake          word
//   req      in         req_valid/stall    op, reg_offset, write_data
//   rsp      out        rsp_valid/stall    read_data, irq_fire, irq_vector
//
// One word per cycle while req_stall is low; its result is registered before it is shown.
// The core updates its registers in the cycle the word is taken.
// Result register plus one skid entry; req_stall rises only when both hold.
// Synchronous reset clears timer state and both result slots.
module apic_countdown_timer_top
   import apic_tmr_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         accept;
   logic         take;
   rsp_word_type result;

   logic         main_valid_ff, main_valid_in;
   rsp_word_type main_word_ff, main_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_word_ff;
   assign take      = main_valid_ff && !rsp_stall;

   apic_tmr_core #(
      .COUNT_BITS(COUNT_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .word  (req_word),
      .result(result)
   );

   always_comb begin
      main_valid_in = main_valid_ff;
      main_word_in  = main_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = accept;
            main_word_in  = result;
         end
      end else if (accept) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_word_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

/* src/apic_tmr_checker.sv */
// Port-level assertions for the APIC timer top level, with bind.
module apic_tmr_checker
   import apic_tmr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("request stalled without output backpressure");

   a_irq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.irq_fire |-> rsp_word.read_data == '0)
      else $error("interrupt word carries read data");

   a_vector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.irq_fire |-> rsp_word.irq_vector == '0)
      else $error("vector without interrupt");

endmodule

bind apic_countdown_timer_top apic_tmr_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_word (rsp_word)
);

/* bench/apic_timer_checker.sv */
// Checker for the APIC timer: predicts each result word from accepted requests and compares.
module apic_timer_checker
   import apic_tmr_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending,
   output int           words_done,
   output int           irq_seen
);

   logic [7:0]            lvt_vector;
   logic                  lvt_masked;
   logic [1:0]            lvt_mode;
   logic [COUNT_BITS-1:0] initial_count;
   logic [COUNT_BITS-1:0] current_count;
   logic [3:0]            divide_code;
   logic [6:0]            prescale;

   rsp_word_type timer_results[$];
   int errors = 0;
   int checked = 0;
   int irqs = 0;

   assign fail_count = errors;
   assign pending    = timer_results.size();
   assign words_done = checked;
   assign irq_seen   = irqs;

   function automatic int unsigned tick_divisor(input logic [3:0] code);
      logic [2:0] sel;
      sel = {code[3], code[1:0]};
      case (sel)
         3'd0: return 2;
         3'd1: return 4;
         3'd2: return 8;
         3'd3: return 16;
         3'd4: return 32;
         3'd5: return 64;
         3'd6: return 128;
         default: return 1;
      endcase
   endfunction

   task automatic clear_timer();
      lvt_vector    = '0;
      lvt_masked    = 1'b1;
      lvt_mode      = '0;
      initial_count = '0;
      current_count = '0;
      divide_code   = '0;
      prescale      = '0;
   endtask

   task automatic timer_step(input req_word_type w, output rsp_word_type r);
      r = '0;
      case (w.op)
         OP_TICK: begin
            if (current_count != '0) begin
               if (32'(prescale) + 1 < tick_divisor(divide_code)) begin
                  prescale = prescale + 7'd1;
               end else begin
                  prescale = '0;
                  current_count = current_count - 1'b1;
                  if (current_count == '0) begin
                     if (lvt_mode == MODE_PERIODIC) begin
                        current_count = initial_count;
                     end
                     if (!lvt_masked) begin
                        r.irq_fire   = 1'b1;
                        r.irq_vector = lvt_vector;
                     end
                  end
               end
            end
         end
         OP_READ: begin
            case (w.reg_offset)
               OFS_LVT_TIMER:  r.read_data = {13'd0, lvt_mode, lvt_masked, 8'd0, lvt_vector};
               OFS_INIT_COUNT: r.read_data = 32'(initial_count);
               OFS_CUR_COUNT:  r.read_data = 32'(current_count);
               OFS_DIVIDE:     r.read_data = {28'd0, divide_code};
               default:        r.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (w.reg_offset)
               OFS_LVT_TIMER: begin
                  lvt_vector = w.write_data[7:0];
                  lvt_masked = w.write_data[16];
                  lvt_mode   = w.write_data[18:17];
               end
               OFS_INIT_COUNT: begin
                  initial_count = COUNT_BITS'(w.write_data);
                  current_count = initial_count;
                  prescale      = '0;
               end
               OFS_DIVIDE: divide_code = w.write_data[3:0];
               default: ;
            endcase
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         clear_timer();
         timer_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (timer_results.size() == 0) begin
               $error("result word with no expectation waiting: %h", rsp_word);
               errors++;
            end else begin
               want = timer_results.pop_front();
               checked++;
               if (rsp_word.irq_fire) begin
                  irqs++;
               end
               if (rsp_word.read_data !== want.read_data) begin
                  $error("read_data expected %h actual %h", want.read_data, rsp_word.read_data);
                  errors++;
               end
               if (rsp_word.irq_fire !== want.irq_fire) begin
                  $error("irq_fire expected %b actual %b", want.irq_fire, rsp_word.irq_fire);
                  errors++;
               end
               if (rsp_word.irq_vector !== want.irq_vector) begin
                  $error("irq_vector expected %h actual %h", want.irq_vector,
                         rsp_word.irq_vector);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            timer_step(req_word, want);
            timer_results.push_back(want);
         end
      end
   end

endmodule

/* bench/testbench.sv */
// Testbench top for the APIC timer: clock, reset, request and result pacing, verdict.
module testbench;
   import apic_tmr_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         PHASE_WORDS = 475;
   localparam int         HOLD_CYCLES = 60;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   int fail_count;
   int pending;
   int words_done;
   int irq_seen;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off_request = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   apic_countdown_timer_top #(.COUNT_BITS(32)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   apic_timer_checker #(.COUNT_BITS(32)) timer_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending),
      .words_done (words_done),
      .irq_seen   (irq_seen)
   );

   function automatic req_word_type make_word(input logic [1:0] op, input logic [9:0] ofs,
                                              input logic [31:0] data);
      req_word_type w;
      w.op         = op;
      w.reg_offset = ofs;
      w.write_data = data;
      return w;
   endfunction

   // mostly ticks and timer programming with small counts and fast divides, plus noise
   function automatic req_word_type next_random_word();
      req_word_type w;
      int pick;
      int reg_pick;
      int count_pick;
      w.op         = OP_TICK;
      w.reg_offset = 10'($urandom);
      w.write_data = $urandom;
      pick = $urandom_range(99);
      if (pick < 55) begin
         w.op = OP_TICK;
      end else if (pick < 72) begin
         w.op = OP_READ;
         if ($urandom_range(99) < 85) begin
            case ($urandom_range(3))
               0: w.reg_offset = OFS_LVT_TIMER;
               1: w.reg_offset = OFS_INIT_COUNT;
               2: w.reg_offset = OFS_CUR_COUNT;
               default: w.reg_offset = OFS_DIVIDE;
            endcase
         end
      end else if (pick < 96) begin
         w.op = OP_WRITE;
         reg_pick = $urandom_range(99);
         if (reg_pick < 25) begin
            w.reg_offset = OFS_LVT_TIMER;
            w.write_data[16] = ($urandom_range(99) < 25);
         end else if (reg_pick < 65) begin
            w.reg_offset = OFS_INIT_COUNT;
            count_pick = $urandom_range(99);
            if (count_pick < 70) begin
               w.write_data = $urandom_range(24, 1);
            end else if (count_pick < 80) begin
               w.write_data = '0;
            end
         end else if (reg_pick < 85) begin
            w.reg_offset = OFS_DIVIDE;
            if ($urandom_range(99) < 60) begin
               case ($urandom_range(3))
                  0: w.write_data[3:0] = 4'hB;
                  1: w.write_data[3:0] = 4'h0;
                  2: w.write_data[3:0] = 4'h1;
                  default: w.write_data[3:0] = 4'hF;
               endcase
            end
         end else if (reg_pick < 92) begin
            w.reg_offset = OFS_CUR_COUNT;
         end
      end else begin
         w.op = OP_UNUSED;
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : result_side
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      req_word_type opening[$];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      opening.push_back(make_word(OP_READ, OFS_LVT_TIMER, '0));
      opening.push_back(make_word(OP_READ, OFS_INIT_COUNT, '0));
      opening.push_back(make_word(OP_READ, OFS_CUR_COUNT, '0));
      opening.push_back(make_word(OP_READ, OFS_DIVIDE, '0));
      opening.push_back(make_word(OP_READ, 10'h000, 32'hFFFF_FFFF));
      opening.push_back(make_word(OP_READ, 10'h3FF, '0));
      opening.push_back(make_word(OP_WRITE, 10'h3FF, 32'hFFFF_FFFF));
      opening.push_back(make_word(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF));
      opening.push_back(make_word(OP_TICK, '0, '0));
      // reserved divide bit set: acts as divide by one
      opening.push_back(make_word(OP_WRITE, OFS_DIVIDE, 32'hFFFF_FFFF));
      // periodic, unmasked, vector ff, junk in unused bits
      opening.push_back(make_word(OP_WRITE, OFS_LVT_TIMER, 32'hFFFA_FFFF));
      opening.push_back(make_word(OP_WRITE, OFS_INIT_COUNT, 32'd2));
      opening.push_back(make_word(OP_TICK, '0, '0));
      opening.push_back(make_word(OP_TICK, '0, '0));
      opening.push_back(make_word(OP_READ, OFS_CUR_COUNT, '0));
      opening.push_back(make_word(OP_WRITE, OFS_CUR_COUNT, 32'h55));
      opening.push_back(make_word(OP_TICK, '0, '0));
      opening.push_back(make_word(OP_TICK, '0, '0));
      // masked one-shot crossing, then unmask with reserved mode
      opening.push_back(make_word(OP_WRITE, OFS_LVT_TIMER, 32'h0001_0040));
      opening.push_back(make_word(OP_TICK, '0, '0));
      opening.push_back(make_word(OP_TICK, '0, '0));
      opening.push_back(make_word(OP_WRITE, OFS_LVT_TIMER, 32'h0006_0040));
      opening.push_back(make_word(OP_TICK, '0, '0));
      opening.push_back(make_word(OP_WRITE, OFS_INIT_COUNT, '0));
      opening.push_back(make_word(OP_WRITE, OFS_INIT_COUNT, 32'hFFFF_FFFF));
      opening.push_back(make_word(OP_READ, OFS_INIT_COUNT, '0));
      foreach (opening[i]) begin
         send_word(opening[i]);
      end
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 21;
               recv_stall_pct = 67;
            end
            1: begin
               send_idle_pct  = 67;
               recv_stall_pct = 21;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_off_request = 1'b1;
            end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(next_random_word());
         end
         drain_results();
      end

      repeat (10) @(posedge clock);
      $display("Checked %0d result words, %0d carrying a timer interrupt,", words_done,
               irq_seen);
      $display("across three pacing phases and one long result hold-off.");
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* apic_countdown_timer_top.f */
src/apic_tmr_pkg.sv
src/apic_tmr_core.sv
src/apic_countdown_timer_top.sv
src/apic_tmr_checker.sv
bench/apic_timer_checker.sv
bench/testbench.sv
